[hw/rtl/stt_pkg.sv]
// Package for the software timer table: timer entry type, request and status codes.
`default_nettype none
package stt_pkg;

    localparam int POOL_DEPTH_DEF = 16;

    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_BAD_TASK  = 2'd2;
    localparam logic [1:0] STS_POOL_FULL = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [7:0]  task_id;
        logic [7:0]  sig;
        logic [31:0] count;
        logic [31:0] period;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PASS,
        ST_FLUSH
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/software_timer_table.sv]
// Top level of the software timer table: cell chain and request sequencer.
//
// Requests arrive on the s_ channel, one word each; tuser carries the request
// type and tdata the key, duration, periodic flag and elapsed count. Results
// leave on the m_ channel; tlast marks the final word for a request.
// The timers live in a chain of POOL_DEPTH cells kept in list order, newest
// first. Every request that touches the list rotates the whole chain once,
// one cell per cycle while not stalled as described below; a tick then
// sends its final expiry word from the flush state. One request is
// handled at a time, and a rejected request does not rotate the chain.
// Set and remove give one result word; a tick gives one word per expired
// timer, in list order, and none if nothing expires. Expiry words are held
// back by one so that tlast can be marked on the final one.
// If the receiver stalls, a tick's rotation waits while the output register
// holds an unaccepted word, and a set or remove waits before its decision;
// a finished word waits in the output register and the next request is
// still accepted. Reset empties the list, clears the counters and sets the
// task table size to 256. The size register is written on cfg_valid.
`default_nettype none
module software_timer_table
    import stt_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // task_id[7:0], signal[15:8], duration[47:16], periodic[48], elapsed[80:49]
    input  wire logic [87:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // expired_task[7:0], expired_signal[15:8], slots_used[20:16], slots_used_peak[25:21]
    output logic [31:0]      m_tdata,
    // status[1:0], expired[2]
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    localparam int CW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int UW = $clog2(POOL_DEPTH + 1);

    state_t state_reg, state_next;

    logic [8:0]    tts_reg;
    logic [1:0]    req_reg;
    logic [7:0]    task_reg, sig_reg;
    logic [31:0]   dur_reg, el_reg;
    logic          per_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [UW-1:0] used_reg, used_next, peak_reg, peak_next;
    entry_t        buf_reg, buf_next;

    logic          pend_reg, pend_next;
    logic [7:0]    pend_task_reg, pend_task_next, pend_sig_reg, pend_sig_next;
    logic [UW-1:0] pend_used_reg, pend_used_next;

    logic          out_valid_reg;
    logic [1:0]    out_sts_reg;
    logic          out_exp_reg, out_last_reg;
    logic [7:0]    out_task_reg, out_sig_reg;
    logic [UW-1:0] out_used_reg, out_peak_reg;

    logic          load;
    logic [1:0]    load_sts;
    logic          load_exp, load_last;
    logic [7:0]    load_task, load_sig;
    logic [UW-1:0] load_used;

    logic          step;
    entry_t        push;
    entry_t        proc;
    logic          expire;
    logic [31:0]   dec;

    entry_t        cell_q [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] match_vec;
    logic          found, out_free;

    genvar gi;
    generate
        for (gi = 0; gi < POOL_DEPTH; gi++) begin : g_cell
            entry_t cell_d;
            if (gi == POOL_DEPTH - 1) begin : g_tail
                assign cell_d = push;
            end else begin : g_mid
                assign cell_d = cell_q[gi+1];
            end
            stt_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift    (step),
                .d        (cell_d),
                .key_task (task_reg),
                .key_sig  (sig_reg),
                .q        (cell_q[gi]),
                .match    (match_vec[gi])
            );
        end
    endgenerate

    assign found     = |match_vec;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Work on the entry leaving the head cell.
    always_comb begin
        proc   = cell_q[0];
        expire = 1'b0;
        dec    = (el_reg < cell_q[0].count) ? cell_q[0].count - el_reg : 32'd0;
        case (req_reg)
            REQ_SET: begin
                if (match_vec[0]) begin
                    proc.count = dur_reg;
                end
            end
            REQ_REMOVE: begin
                if (match_vec[0]) begin
                    proc.valid = 1'b0;
                end
            end
            REQ_TICK: begin
                if (cell_q[0].valid) begin
                    proc.count = dec;
                    if (dec == 32'd0) begin
                        expire = 1'b1;
                        if (cell_q[0].period != 32'd0) begin
                            proc.count = cell_q[0].period;
                        end else begin
                            proc.valid = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        used_next      = used_reg;
        peak_next      = peak_reg;
        buf_next       = buf_reg;
        pend_next      = pend_reg;
        pend_task_next = pend_task_reg;
        pend_sig_next  = pend_sig_reg;
        pend_used_next = pend_used_reg;
        step           = 1'b0;
        push           = proc;
        load           = 1'b0;
        load_sts       = STS_OK;
        load_exp       = 1'b0;
        load_last      = 1'b1;
        load_task      = 8'd0;
        load_sig       = 8'd0;
        load_used      = used_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cnt_next      = '0;
                buf_next      = proc;
                buf_next.valid = 1'b0;
                if (req_reg == REQ_TICK) begin
                    state_next = (used_reg == '0) ? ST_IDLE : ST_PASS;
                end else if (req_reg == REQ_SET || req_reg == REQ_REMOVE) begin
                    if (out_free) begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                        if ({1'b0, task_reg} >= tts_reg) begin
                            load_sts = STS_BAD_TASK;
                        end else if (req_reg == REQ_REMOVE) begin
                            if (found) begin
                                used_next  = used_reg - 1'b1;
                                load_used  = used_reg - 1'b1;
                                state_next = ST_PASS;
                            end else begin
                                load_sts = STS_NOT_FOUND;
                            end
                        end else if (found) begin
                            state_next = ST_PASS;
                        end else if (used_reg == UW'(POOL_DEPTH)) begin
                            load_sts = STS_POOL_FULL;
                        end else begin
                            used_next       = used_reg + 1'b1;
                            load_used       = used_reg + 1'b1;
                            if (used_reg + 1'b1 > peak_reg) begin
                                peak_next = used_reg + 1'b1;
                            end
                            buf_next.valid   = 1'b1;
                            buf_next.task_id = task_reg;
                            buf_next.sig     = sig_reg;
                            buf_next.count   = dur_reg;
                            buf_next.period  = per_reg ? dur_reg : 32'd0;
                            state_next       = ST_PASS;
                        end
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PASS: begin
                step = (req_reg == REQ_TICK) ? out_free : 1'b1;
                if (step) begin
                    // A held entry goes out first; a gap in the stream drains it.
                    if (buf_reg.valid) begin
                        push = buf_reg;
                        buf_next = proc;
                    end else begin
                        push = proc;
                    end
                    if (expire) begin
                        if (!proc.valid) begin
                            used_next = used_reg - 1'b1;
                        end
                        if (pend_reg) begin
                            load      = 1'b1;
                            load_exp  = 1'b1;
                            load_last = 1'b0;
                            load_task = pend_task_reg;
                            load_sig  = pend_sig_reg;
                            load_used = pend_used_reg;
                        end
                        pend_next      = 1'b1;
                        pend_task_next = cell_q[0].task_id;
                        pend_sig_next  = cell_q[0].sig;
                        pend_used_next = proc.valid ? used_reg : used_reg - 1'b1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(POOL_DEPTH - 1)) begin
                        state_next = (req_reg == REQ_TICK) ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    load       = 1'b1;
                    load_exp   = 1'b1;
                    load_task  = pend_task_reg;
                    load_sig   = pend_sig_reg;
                    load_used  = pend_used_reg;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tts_reg       <= 9'd256;
            used_reg      <= '0;
            peak_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            pend_reg      <= pend_next;
            if (cfg_valid) begin
                tts_reg <= cfg_data;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg.valid <= 1'b0;
        end else begin
            buf_reg.valid <= buf_next.valid;
        end
        cnt_reg          <= cnt_next;
        buf_reg.task_id  <= buf_next.task_id;
        buf_reg.sig      <= buf_next.sig;
        buf_reg.count    <= buf_next.count;
        buf_reg.period   <= buf_next.period;
        pend_task_reg    <= pend_task_next;
        pend_sig_reg     <= pend_sig_next;
        pend_used_reg    <= pend_used_next;
        if (s_tvalid && s_tready) begin
            req_reg  <= s_tuser;
            task_reg <= s_tdata[7:0];
            sig_reg  <= s_tdata[15:8];
            dur_reg  <= s_tdata[47:16];
            per_reg  <= s_tdata[48];
            el_reg   <= s_tdata[80:49];
        end
        if (load) begin
            out_sts_reg  <= load_sts;
            out_exp_reg  <= load_exp;
            out_last_reg <= load_last;
            out_task_reg <= load_task;
            out_sig_reg  <= load_sig;
            out_used_reg <= load_used;
            out_peak_reg <= peak_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_exp_reg, out_sts_reg};
    assign m_tdata  = {6'd0, 5'(out_peak_reg), 5'(out_used_reg), out_sig_reg, out_task_reg};

endmodule
`default_nettype wire

[hw/rtl/stt_cell.sv]
// One timer cell of the rotating chain: holds an entry and compares its key.
`default_nettype none
module stt_cell
    import stt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       shift,
    input  wire entry_t     d,
    input  wire logic [7:0] key_task,
    input  wire logic [7:0] key_sig,
    output entry_t          q,
    output logic            match
);

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else if (shift) begin
            entry_reg.valid <= d.valid;
        end
        if (shift) begin
            entry_reg.task_id <= d.task_id;
            entry_reg.sig     <= d.sig;
            entry_reg.count   <= d.count;
            entry_reg.period  <= d.period;
        end
    end

    assign q     = entry_reg;
    assign match = entry_reg.valid && (entry_reg.task_id == key_task)
                   && (entry_reg.sig == key_sig);

endmodule
`default_nettype wire
